/* rtl/aat_pkg.sv */
package aat_pkg;

    // Table geometry and address width.
    localparam int TABLE_DEPTH = 8;
    localparam int ADDR_W      = 48;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef addr_t [TABLE_DEPTH-1:0] table_t;

    localparam addr_t EMPTY_ADDR = '0;

    // Operation codes carried by each input transfer.
    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Lookup results from the comparator bank.
    typedef struct packed {
        logic hit;
        idx_t hit_idx;
        logic free_found;
        idx_t free_idx;
    } match_t;

    // Update request applied to the table.
    typedef struct packed {
        logic  wr_en;
        logic  clear_all;
        idx_t  wr_idx;
        addr_t wr_data;
    } table_wr_t;

endpackage

/* rtl/aat_match.sv */
module aat_match
    import aat_pkg::*;
(
    input  table_t entries,
    input  addr_t  key,
    output match_t result
);

    logic [TABLE_DEPTH-1:0] eq_key;
    logic [TABLE_DEPTH-1:0] eq_empty;

    // One comparator per slot against the key and against the empty marker.
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            eq_key[i]   = (entries[i] == key);
            eq_empty[i] = (entries[i] == EMPTY_ADDR);
        end
    end

    // Lowest-slot priority encoders; scanning downward leaves the lowest match.
    always_comb
    begin
        result = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (eq_key[i])
            begin
                result.hit     = 1'b1;
                result.hit_idx = idx_t'(i);
            end
            if (eq_empty[i])
            begin
                result.free_found = 1'b1;
                result.free_idx   = idx_t'(i);
            end
        end
    end

endmodule

/* rtl/aat_table.sv */
module aat_table
    import aat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  table_wr_t wr,
    output table_t    entries
);

    table_t entries_reg;
    table_t entries_next;

    // Apply a clear of all slots or a single-slot write.
    always_comb
    begin
        entries_next = entries_reg;
        if (wr.clear_all)
        begin
            entries_next = '0;
        end
        else if (wr.wr_en)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (wr.wr_idx == idx_t'(i))
                begin
                    entries_next[i] = wr.wr_data;
                end
            end
        end
    end

    // Every slot is empty after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else
        begin
            entries_reg <= entries_next;
        end
    end

    assign entries = entries_reg;

endmodule

/* rtl/address_allowlist_table_core.sv */
// Device address accept list with an eight-slot table of 48-bit addresses.
// Commands: an operation (check, add, remove, clear all) and an address are
// taken at a rising edge where start is high and busy is low. Busy is always
// low, so a command may be issued in every cycle.
// Results: each command yields one ok flag on the ok port, marked by a
// one-cycle done strobe, after the command has passed through the input
// register and then the result register. One command per cycle
// is sustained; the comparator bank and lowest-slot encoder in front of the
// result register set that cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Configuration: the enforce_enable bit is written through cfg_valid and
// cfg_data; cfg_ready is always high. Write it only while no command is
// in flight.
// Reset: asynchronous, active low; all slots become empty, enforcement is
// switched off and no result is pending.
module address_allowlist_table_core
    import aat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [47:0] device_address,
    output logic        done,
    output logic        ok,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic      in_valid_reg;
    op_t       op_reg;
    addr_t     addr_reg;
    logic      enforce_reg;
    logic      done_reg;
    logic      ok_reg;
    logic      ok_next;
    logic      listed;
    table_t    entries;
    match_t    match;
    table_wr_t tbl_wr;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enforce_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            enforce_reg <= cfg_data;
        end
    end

    // Input register: valid flag is control, the payload is not reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg   <= op_t'(op);
            addr_reg <= device_address;
        end
    end

    aat_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .entries (entries)
    );

    aat_match u_match (
        .entries (entries),
        .key     (addr_reg),
        .result  (match)
    );

    // The empty marker is never a listed address.
    assign listed = match.hit && (addr_reg != EMPTY_ADDR);

    // Decode the operation into a table update and a result flag.
    always_comb
    begin
        tbl_wr  = '0;
        ok_next = 1'b0;
        case (op_reg)
            OP_CHECK:
            begin
                ok_next = !enforce_reg || listed;
            end
            OP_ADD:
            begin
                if (addr_reg != EMPTY_ADDR && !listed && match.free_found)
                begin
                    tbl_wr.wr_en   = in_valid_reg;
                    tbl_wr.wr_idx  = match.free_idx;
                    tbl_wr.wr_data = addr_reg;
                    ok_next        = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (listed)
                begin
                    tbl_wr.wr_en   = in_valid_reg;
                    tbl_wr.wr_idx  = match.hit_idx;
                    tbl_wr.wr_data = EMPTY_ADDR;
                    ok_next        = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                tbl_wr.clear_all = in_valid_reg;
                ok_next          = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Result register and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            ok_reg <= ok_next;
        end
    end

    assign done = done_reg;
    assign ok   = ok_reg;

    // A result strobe follows exactly one registered command.
    a_done_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid_reg))
        else $error("result strobe without a command");

    // Clear always succeeds and empties the table.
    a_clear_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && op_reg == OP_CLEAR) |=> (done && ok && entries == '0))
        else $error("clear did not succeed");

    // Adding the empty marker never succeeds and leaves the table as is.
    a_add_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && op_reg == OP_ADD && addr_reg == EMPTY_ADDR)
        |=> (!ok && $stable(entries)))
        else $error("add of the zero address changed state");

    // With enforcement off every check is allowed.
    a_check_open: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && op_reg == OP_CHECK && !enforce_reg) |=> ok)
        else $error("check refused while enforcement is off");

endmodule
